[rtl/core/vgrw_pkg.sv]
`timescale 1ns / 1ps

package vgrw_pkg;

    // Divider geometry: the numerator is at most 2^39, the divisor at most 2^15.
    localparam int NUM_W = 40;
    localparam int DEN_W = 16;
    localparam int REM_W = 16;
    localparam int LANES = 6;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [3:0]  CS_MAX   = 4'd8;

    // Internal axis codes.
    localparam logic [1:0] AX_X    = 2'd0;
    localparam logic [1:0] AX_Y    = 2'd1;
    localparam logic [1:0] AX_Z    = 2'd2;
    localparam logic [1:0] AX_NONE = 2'd3;

    // External axis and step codes.
    localparam logic [2:0] XAX_NONE = 3'b111;
    localparam logic [1:0] SG_POS   = 2'b01;
    localparam logic [1:0] SG_NEG   = 2'b11;
    localparam logic [1:0] SG_ZERO  = 2'b00;

    typedef logic [LANES-1:0][NUM_W-1:0] t_num_arr;
    typedef logic [LANES-1:0][DEN_W-1:0] t_den_arr;

    // Per-ray data that rides alongside the divider lanes.
    typedef struct packed {
        logic [31:0]      t0;
        logic [31:0]      t1;
        logic [2:0][15:0] cidx;
        logic [2:0]       neg;
        logic [2:0]       zero;
        logic [1:0]       ax;
        logic             empty;
    } t_side;

    // Fully set-up ray handed to the walker.
    typedef struct packed {
        logic [2:0][15:0] cidx;
        logic [2:0][31:0] nb;
        logic [2:0][31:0] span;
        logic [2:0][1:0]  sdir;
        logic [31:0]      t0;
        logic [31:0]      t1;
        logic [1:0]       ax;
        logic             empty;
    } t_ray;

endpackage

[rtl/core/vgrw_div.sv]
`timescale 1ns / 1ps

module vgrw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  vgrw_pkg::t_side   i_side,
    input  vgrw_pkg::t_num_arr i_num,
    input  vgrw_pkg::t_den_arr i_den,
    output logic              o_valid,
    output vgrw_pkg::t_side   o_side,
    output vgrw_pkg::t_num_arr o_quo
);
    import vgrw_pkg::*;

    localparam int BITS_PER_STG = 2;
    localparam int NSTG         = NUM_W / BITS_PER_STG;

    typedef logic [LANES-1:0][REM_W-1:0] t_rem_arr;

    logic     r_valid [1:NSTG];
    t_side    r_side  [1:NSTG];
    t_num_arr r_num   [1:NSTG];
    t_rem_arr r_rem   [1:NSTG];
    t_den_arr r_den   [1:NSTG];

    // Restoring division, quotient bits shifted into the numerator's low end.
    for (genvar s = 0; s < NSTG; s++) begin : g_stg
        logic     pv;
        t_side    ps;
        t_num_arr pn;
        t_rem_arr pr;
        t_den_arr pd;
        t_num_arr n_num;
        t_rem_arr n_rem;

        if (s == 0) begin : g_first
            assign pv = i_valid;
            assign ps = i_side;
            assign pn = i_num;
            assign pr = '0;
            assign pd = i_den;
        end else begin : g_next
            assign pv = r_valid[s];
            assign ps = r_side[s];
            assign pn = r_num[s];
            assign pr = r_rem[s];
            assign pd = r_den[s];
        end

        always_comb begin
            logic [REM_W:0] trial;
            logic           ge;
            n_num = pn;
            n_rem = pr;
            for (int l = 0; l < LANES; l++) begin
                for (int b = 0; b < BITS_PER_STG; b++) begin
                    trial    = {n_rem[l], n_num[l][NUM_W-1]};
                    ge       = trial >= {1'b0, pd[l]};
                    n_rem[l] = ge ? REM_W'(trial - {1'b0, pd[l]}) : trial[REM_W-1:0];
                    n_num[l] = {n_num[l][NUM_W-2:0], ge};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[s+1] <= pv;
            end
            if (i_en) begin
                r_side[s+1] <= ps;
                r_num[s+1]  <= n_num;
                r_rem[s+1]  <= n_rem;
                r_den[s+1]  <= pd;
            end
        end
    end

    assign o_valid = r_valid[NSTG];
    assign o_side  = r_side[NSTG];
    assign o_quo   = r_num[NSTG];

endmodule

[rtl/core/vgrw_setup.sv]
`timescale 1ns / 1ps

module vgrw_setup #(
    parameter int COORD_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [3:0]              i_cell_shift,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [2:0][31:0]        i_org,
    input  logic [2:0][15:0]        i_dir,
    input  logic [31:0]             i_t0,
    input  logic [31:0]             i_t1,
    input  logic [2:0]              i_entry_axis,
    input  logic                    i_ready,
    output logic                    o_valid,
    output vgrw_pkg::t_ray          o_ray
);
    import vgrw_pkg::*;

    localparam int PW = COORD_BITS + 2;

    logic en;

    // Stage A: capture, magnitude and sign of direction.
    logic        r_a_valid;
    t_side       r_a_side;
    logic [31:0] r_a_org [3];
    logic [15:0] r_a_mag [3];
    logic [3:0]  r_a_cs;
    // Stage M: product magnitude.
    logic        r_m_valid;
    t_side       r_m_side;
    logic [31:0] r_m_org [3];
    logic [15:0] r_m_mag [3];
    logic [47:0] r_m_prod [3];
    logic [3:0]  r_m_cs;
    // Stage P: entry point.
    logic                 r_p_valid;
    t_side                r_p_side;
    logic signed [PW-1:0] r_p_pos [3];
    logic [15:0]          r_p_mag [3];
    logic [3:0]           r_p_cs;
    // Stage D: cell, boundary distance, divider operands.
    logic     r_d_valid;
    t_side    r_d_side;
    t_num_arr r_d_num;
    t_den_arr r_d_den;
    // Stage C: finished ray.
    logic     r_c_valid;
    t_ray     r_c_ray;

    logic     dv_valid;
    t_side    dv_side;
    t_num_arr dv_quo;

    logic signed [PW-1:0] n_pos [3];
    t_side    n_d_side;
    t_num_arr n_d_num;
    t_den_arr n_d_den;
    t_ray     n_c_ray;

    assign en      = !r_c_valid || i_ready;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_valid;
            r_m_valid <= r_a_valid;
            r_p_valid <= r_m_valid;
            r_d_valid <= r_p_valid;
        end
        if (en) begin
            r_a_side.t0    <= i_t0;
            r_a_side.t1    <= i_t1;
            r_a_side.cidx  <= '0;
            r_a_side.empty <= i_t0 > i_t1;
            r_a_side.ax    <= (i_entry_axis <= 3'd2) ? i_entry_axis[1:0] : AX_NONE;
            r_a_cs         <= i_cell_shift;
            for (int i = 0; i < 3; i++) begin
                r_a_org[i]       <= i_org[i];
                r_a_mag[i]       <= i_dir[i][15] ? 16'(-i_dir[i]) : i_dir[i];
                r_a_side.neg[i]  <= i_dir[i][15];
                r_a_side.zero[i] <= i_dir[i] == 16'd0;
            end
            r_m_side <= r_a_side;
            r_m_cs   <= r_a_cs;
            for (int i = 0; i < 3; i++) begin
                r_m_org[i]  <= r_a_org[i];
                r_m_mag[i]  <= r_a_mag[i];
                r_m_prod[i] <= 48'(r_a_mag[i]) * 48'(r_a_side.t0);
            end
            r_p_side <= r_m_side;
            r_p_cs   <= r_m_cs;
            for (int i = 0; i < 3; i++) begin
                r_p_pos[i] <= n_pos[i];
                r_p_mag[i] <= r_m_mag[i];
            end
            r_d_side <= n_d_side;
            r_d_num  <= n_d_num;
            r_d_den  <= n_d_den;
        end
    end

    // Entry point p = origin + floor(dir * t0 / 2^15), wrapped to PW bits.
    always_comb begin
        logic signed [48:0] sprod;
        logic signed [33:0] sh15;
        logic signed [34:0] sum;
        for (int i = 0; i < 3; i++) begin
            sprod    = r_m_side.neg[i] ? -$signed({1'b0, r_m_prod[i]})
                                       :  $signed({1'b0, r_m_prod[i]});
            sh15     = 34'(sprod >>> 15);
            sum      = 35'($signed(r_m_org[i])) + 35'(sh15);
            n_pos[i] = PW'(sum);
        end
    end

    // Floor cell and distance to the next boundary in the step direction.
    always_comb begin
        logic [4:0]  shv;
        logic [24:0] edge_len;
        logic [24:0] low;
        logic [24:0] bdist;
        shv      = 5'd16 + 5'(r_p_cs);
        edge_len = 25'd1 << shv;
        n_d_side = r_p_side;
        for (int i = 0; i < 3; i++) begin
            n_d_side.cidx[i] = 16'(r_p_pos[i] >>> shv);
            low              = 25'(r_p_pos[i]) & (edge_len - 25'd1);
            bdist            = r_p_side.neg[i] ? low : edge_len - low;
            n_d_num[i]       = NUM_W'(bdist) << 15;
            n_d_num[i+3]     = NUM_W'(1) << (6'(shv) + 6'd15);
            n_d_den[i]       = r_p_side.zero[i] ? DEN_W'(1) : r_p_mag[i];
            n_d_den[i+3]     = r_p_side.zero[i] ? DEN_W'(1) : r_p_mag[i];
        end
    end

    vgrw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_d_valid),
        .i_side  (r_d_side),
        .i_num   (r_d_num),
        .i_den   (r_d_den),
        .o_valid (dv_valid),
        .o_side  (dv_side),
        .o_quo   (dv_quo)
    );

    // Saturate boundary and span times; a still axis never crosses.
    always_comb begin
        logic [40:0] sum;
        n_c_ray.cidx  = dv_side.cidx;
        n_c_ray.t0    = dv_side.t0;
        n_c_ray.t1    = dv_side.t1;
        n_c_ray.ax    = dv_side.ax;
        n_c_ray.empty = dv_side.empty;
        for (int i = 0; i < 3; i++) begin
            sum = 41'(dv_side.t0) + 41'(dv_quo[i]);
            if (dv_side.zero[i]) begin
                n_c_ray.nb[i]   = ALL_ONES;
                n_c_ray.span[i] = ALL_ONES;
                n_c_ray.sdir[i] = SG_ZERO;
            end else begin
                n_c_ray.nb[i]   = (|sum[40:32]) ? ALL_ONES : sum[31:0];
                n_c_ray.span[i] = (|dv_quo[i+3][NUM_W-1:32]) ? ALL_ONES
                                                               : dv_quo[i+3][31:0];
                n_c_ray.sdir[i] = dv_side.neg[i] ? SG_NEG : SG_POS;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (en) begin
            r_c_valid <= dv_valid;
        end
        if (en) begin
            r_c_ray <= n_c_ray;
        end
    end

    assign o_valid = r_c_valid;
    assign o_ray   = r_c_ray;

endmodule

[rtl/core/vgrw_walk.sv]
`timescale 1ns / 1ps

module vgrw_walk #(
    parameter int MAX_STEPS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  vgrw_pkg::t_ray     i_ray,
    output logic               o_ready,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output logic signed [15:0] o_cell_x,
    output logic signed [15:0] o_cell_y,
    output logic signed [15:0] o_cell_z,
    output logic [31:0]        o_t_enter,
    output logic signed [2:0]  o_cross_axis,
    output logic signed [1:0]  o_step_sign,
    output logic               o_last,
    output logic               o_empty_res,
    output logic               o_truncated
);
    import vgrw_pkg::*;

    localparam int SW = $clog2(MAX_STEPS + 1);

    logic             r_busy;
    logic             r_empty;
    logic [2:0][15:0] r_cell;
    logic [2:0][31:0] r_nb;
    logic [2:0][31:0] r_span;
    logic [2:0][1:0]  r_sdir;
    logic [31:0]      r_t;
    logic [31:0]      r_t1;
    logic [1:0]       r_ax;
    logic [SW-1:0]    r_steps;

    logic             r_ov;
    logic [2:0][15:0] r_o_cell;
    logic [31:0]      r_o_t;
    logic [2:0]       r_o_ax;
    logic [1:0]       r_o_sg;
    logic             r_o_last;
    logic             r_o_empty;
    logic             r_o_trunc;

    logic          fire;
    logic          load;
    logic [1:0]    amin;
    logic [31:0]   texit;
    logic          done;
    logic          capped;
    logic [SW-1:0] n_steps;
    logic [32:0]   adv_sum;
    logic [31:0]   n_nb;
    logic [1:0]    sg;

    assign fire    = r_busy && (!r_ov || !i_out_stall);
    assign load    = i_valid && !r_busy;
    assign o_ready = !r_busy;

    // Pick the axis with the earliest boundary, ties to the lower axis.
    always_comb begin
        logic        y_lt_x;
        logic [31:0] m01;
        y_lt_x = r_nb[1] < r_nb[0];
        m01    = y_lt_x ? r_nb[1] : r_nb[0];
        if (r_nb[2] < m01) begin
            amin  = AX_Z;
            texit = r_nb[2];
        end else begin
            amin  = y_lt_x ? AX_Y : AX_X;
            texit = m01;
        end
    end

    assign done    = texit > r_t1 || texit == ALL_ONES;
    assign n_steps = r_steps + SW'(1);
    assign capped  = !done && n_steps >= SW'(MAX_STEPS);
    assign adv_sum = 33'(r_nb[amin]) + 33'(r_span[amin]);
    assign n_nb    = adv_sum[32] ? ALL_ONES : adv_sum[31:0];

    always_comb begin
        case (r_ax)
            AX_X:    sg = r_sdir[0];
            AX_Y:    sg = r_sdir[1];
            AX_Z:    sg = r_sdir[2];
            default: sg = SG_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (fire && (r_empty || done || capped)) begin
                r_busy <= 1'b0;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
        if (load) begin
            r_empty <= i_ray.empty;
            r_cell  <= i_ray.cidx;
            r_nb    <= i_ray.nb;
            r_span  <= i_ray.span;
            r_sdir  <= i_ray.sdir;
            r_t     <= i_ray.t0;
            r_t1    <= i_ray.t1;
            r_ax    <= i_ray.ax;
            r_steps <= '0;
        end else if (fire && !r_empty && !done && !capped) begin
            // Advance into the neighbouring cell.
            r_t          <= texit;
            r_cell[amin] <= r_cell[amin] + {{14{r_sdir[amin][1]}}, r_sdir[amin]};
            r_nb[amin]   <= n_nb;
            r_ax         <= amin;
            r_steps      <= n_steps;
        end
        if (fire) begin
            if (r_empty) begin
                r_o_cell  <= '0;
                r_o_t     <= '0;
                r_o_ax    <= XAX_NONE;
                r_o_sg    <= SG_ZERO;
                r_o_last  <= 1'b1;
                r_o_empty <= 1'b1;
                r_o_trunc <= 1'b0;
            end else begin
                r_o_cell  <= r_cell;
                r_o_t     <= r_t;
                r_o_ax    <= (r_ax == AX_NONE) ? XAX_NONE : {1'b0, r_ax};
                r_o_sg    <= sg;
                r_o_last  <= done || capped;
                r_o_empty <= 1'b0;
                r_o_trunc <= capped;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_cell_x     = r_o_cell[0];
    assign o_cell_y     = r_o_cell[1];
    assign o_cell_z     = r_o_cell[2];
    assign o_t_enter    = r_o_t;
    assign o_cross_axis = r_o_ax;
    assign o_step_sign  = r_o_sg;
    assign o_last       = r_o_last;
    assign o_empty_res  = r_o_empty;
    assign o_truncated  = r_o_trunc;

`ifndef ASSERT_OFF
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_empty |-> r_o_last)
        else $error("empty result without last");
    a_trunc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_o_trunc |-> r_o_last && !r_o_empty)
        else $error("truncated result malformed");
    a_step_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !r_empty |-> r_steps < SW'(MAX_STEPS))
        else $error("step count past cap");
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && (r_empty || done || capped) |=> !r_busy)
        else $error("walker still busy after last item");
`endif

endmodule

[rtl/core/voxel_grid_ray_walker_core.sv]
`timescale 1ns / 1ps

// 3D voxel ray walker (Amanatides-Woo grid traversal, fixed point). Each input
// item is one ray; the block emits one item per visited cell, in order, with
// the t at which the cell is entered and the axis crossed. Setup runs through a
// 25-stage pipeline (capture, multiply, entry point, boundary distance, a
// 20-stage radix-4 restoring divider with six lanes, saturation). The walker
// then emits one item per cycle while the output is not stalled; it takes the
// next ray only after the last item of the current one, while later rays
// queue in the setup pipeline.
// cell_shift is sampled with each ray; write it only while the block is idle.
module voxel_grid_ray_walker_core #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic [31:0]        i_t_start,
    input  logic [31:0]        i_t_end,
    input  logic signed [2:0]  i_entry_axis,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_cell_x,
    output logic signed [15:0] o_cell_y,
    output logic signed [15:0] o_cell_z,
    output logic [31:0]        o_t_enter,
    output logic signed [2:0]  o_cross_axis,
    output logic signed [1:0]  o_step_sign,
    output logic               o_last,
    output logic               o_empty_res,
    output logic               o_truncated
);
    import vgrw_pkg::*;

    logic [3:0] r_cell_shift;
    logic       ray_valid;
    logic       walk_ready;
    t_ray       ray;

    // Hold the cell size; clamp anything beyond the largest cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_shift <= '0;
        end else if (i_cfg_we) begin
            r_cell_shift <= (i_cfg_wdata > CS_MAX) ? CS_MAX : i_cfg_wdata;
        end
    end

    vgrw_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cell_shift (r_cell_shift),
        .i_valid      (i_in_valid),
        .o_stall      (o_in_stall),
        .i_org        ({i_origin_z, i_origin_y, i_origin_x}),
        .i_dir        ({i_dir_z, i_dir_y, i_dir_x}),
        .i_t0         (i_t_start),
        .i_t1         (i_t_end),
        .i_entry_axis (i_entry_axis),
        .i_ready      (walk_ready),
        .o_valid      (ray_valid),
        .o_ray        (ray)
    );

    // Walk the grid behind an output register, one cell per cycle while the output is not stalled.
    vgrw_walk #(
        .MAX_STEPS (MAX_STEPS)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (ray_valid),
        .i_ray        (ray),
        .o_ready      (walk_ready),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_cell_x     (o_cell_x),
        .o_cell_y     (o_cell_y),
        .o_cell_z     (o_cell_z),
        .o_t_enter    (o_t_enter),
        .o_cross_axis (o_cross_axis),
        .o_step_sign  (o_step_sign),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res),
        .o_truncated  (o_truncated)
    );

endmodule

[tb/sv/voxel_grid_ray_walker_core_checker.sv]
`timescale 1ns / 1ps

module voxel_grid_ray_walker_core_checker #(
    parameter int MAX_STEPS  = 64,
    parameter int COORD_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [31:0] i_origin_x,
    input  logic signed [31:0] i_origin_y,
    input  logic signed [31:0] i_origin_z,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    input  logic [31:0]        i_t_start,
    input  logic [31:0]        i_t_end,
    input  logic signed [2:0]  i_entry_axis,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [15:0] i_cell_x,
    input  logic signed [15:0] i_cell_y,
    input  logic signed [15:0] i_cell_z,
    input  logic [31:0]        i_t_enter,
    input  logic signed [2:0]  i_cross_axis,
    input  logic signed [1:0]  i_step_sign,
    input  logic               i_last,
    input  logic               i_empty_res,
    input  logic               i_truncated,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_cell_count,
    output int                 o_capped_rays,
    output int                 o_empty_rays
);
    import vgrw_pkg::*;

    typedef struct packed {
        logic [15:0] cx;
        logic [15:0] cy;
        logic [15:0] cz;
        logic [31:0] te;
        logic [2:0]  ax;
        logic [1:0]  sg;
        logic        last;
        logic        empty;
        logic        trunc;
    } t_cell_visit;

    t_cell_visit visits_q[$];
    logic [3:0]  shift_q;

    function automatic logic [31:0] sat_t(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? ALL_ONES : v[31:0];
    endfunction

    // Set up the grid walk for one ray and queue every cell it visits.
    task automatic walk_ray(input logic signed [31:0] org[3], input logic signed [15:0] dv[3],
                            input logic [31:0] t0, input logic [31:0] t1,
                            input logic [2:0] ea);
        logic [15:0]        cidx[3];
        int                 sd[3];
        logic [31:0]        nb[3];
        logic [31:0]        span[3];
        logic signed [63:0] dsx, p, c, prod;
        logic [63:0]        mag, bdist;
        logic [31:0]        cur_t, texit;
        int                 ax, sh, steps, a;
        logic               done, capped;
        t_cell_visit        v;
        sh = 16 + shift_q;
        for (int i = 0; i < 3; i++) begin
            dsx  = dv[i];
            mag  = (dsx < 0) ? -dsx : dsx;
            prod = mag * {32'b0, t0};
            if (dsx < 0) prod = -prod;
            p = org[i];
            p = p + (prod >>> 15);
            p = {{(64 - COORD_BITS - 2){p[COORD_BITS + 1]}}, p[COORD_BITS + 1:0]};
            c = p >>> sh;
            cidx[i] = c[15:0];
            if (mag == 0) begin
                sd[i] = 0;
                nb[i] = ALL_ONES;
                span[i] = ALL_ONES;
            end else begin
                if (dsx > 0) begin
                    sd[i] = 1;
                    bdist = ((c + 1) <<< sh) - p;
                end else begin
                    sd[i] = -1;
                    bdist = p - (c <<< sh);
                end
                nb[i]   = sat_t({32'b0, t0} + ((bdist << 15) / mag));
                span[i] = sat_t((64'd1 << (sh + 15)) / mag);
            end
        end
        cur_t = t0;
        ax    = (ea <= 3'd2) ? int'(ea) : -1;
        if (t0 > t1) begin
            v = '0;
            v.ax = XAX_NONE;
            v.last = 1'b1;
            v.empty = 1'b1;
            visits_q.push_back(v);
            o_empty_rays++;
            return;
        end
        steps = 0;
        while (1) begin
            texit = nb[0];
            if (nb[1] < texit) texit = nb[1];
            if (nb[2] < texit) texit = nb[2];
            done = (texit > t1) || (texit == ALL_ONES);
            steps++;
            capped = !done && (steps >= MAX_STEPS);
            v.cx = cidx[0];
            v.cy = cidx[1];
            v.cz = cidx[2];
            v.te = cur_t;
            v.ax = (ax < 0) ? XAX_NONE : 3'(ax);
            v.sg = (ax < 0) ? SG_ZERO : 2'(sd[ax]);
            v.last = done || capped;
            v.empty = 1'b0;
            v.trunc = capped;
            visits_q.push_back(v);
            if (capped) o_capped_rays++;
            if (done || capped) break;
            a = 0;
            if (nb[1] < nb[a]) a = 1;
            if (nb[2] < nb[a]) a = 2;
            cur_t   = nb[a];
            cidx[a] = cidx[a] + 16'(sd[a]);
            nb[a]   = sat_t({32'b0, nb[a]} + {32'b0, span[a]});
            ax      = a;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count  = 0;
        o_pending     = 0;
        o_cell_count  = 0;
        o_capped_rays = 0;
        o_empty_rays  = 0;
        shift_q       = '0;
    end

    always @(posedge i_clk) begin
        t_cell_visit        ev;
        logic signed [31:0] org[3];
        logic signed [15:0] dv[3];
        if (i_rst_n) begin
            if (i_cfg_we) shift_q <= (i_cfg_wdata > CS_MAX) ? CS_MAX : i_cfg_wdata;
            // Compare first: a new ray cannot produce output in its own cycle.
            if (i_out_valid && !i_out_stall) begin
                o_cell_count++;
                if (visits_q.size() == 0) begin
                    $error("unexpected result item");
                    o_fail_count++;
                end else begin
                    ev = visits_q.pop_front();
                    check_field("cell_x", 32'(ev.cx), 32'($unsigned(i_cell_x)));
                    check_field("cell_y", 32'(ev.cy), 32'($unsigned(i_cell_y)));
                    check_field("cell_z", 32'(ev.cz), 32'($unsigned(i_cell_z)));
                    check_field("t_enter", ev.te, i_t_enter);
                    check_field("cross_axis", 32'(ev.ax), 32'($unsigned(i_cross_axis)));
                    check_field("step_sign", 32'(ev.sg), 32'($unsigned(i_step_sign)));
                    check_field("last", 32'(ev.last), 32'(i_last));
                    check_field("empty_res", 32'(ev.empty), 32'(i_empty_res));
                    check_field("truncated", 32'(ev.trunc), 32'(i_truncated));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                org = '{i_origin_x, i_origin_y, i_origin_z};
                dv  = '{i_dir_x, i_dir_y, i_dir_z};
                walk_ray(org, dv, i_t_start, i_t_end, i_entry_axis);
            end
            o_pending = visits_q.size();
        end
    end

endmodule

[tb/sv/voxel_grid_ray_walker_core_tb.sv]
`timescale 1ns / 1ps

module voxel_grid_ray_walker_core_tb;
    import vgrw_pkg::*;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [3:0]         i_cfg_wdata = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [31:0] i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    logic signed [15:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic [31:0]        i_t_start = '0, i_t_end = '0;
    logic signed [2:0]  i_entry_axis = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [15:0] o_cell_x, o_cell_y, o_cell_z;
    logic [31:0]        o_t_enter;
    logic signed [2:0]  o_cross_axis;
    logic signed [1:0]  o_step_sign;
    logic               o_last, o_empty_res, o_truncated;

    int fail_count, pending, cell_count, capped_rays, empty_rays;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int rays_sent = 0;

    always #10 i_clk = ~i_clk;

    voxel_grid_ray_walker_core dut (.*);

    voxel_grid_ray_walker_core_checker checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_in_valid, .i_in_stall(o_in_stall),
        .i_origin_x, .i_origin_y, .i_origin_z, .i_dir_x, .i_dir_y, .i_dir_z,
        .i_t_start, .i_t_end, .i_entry_axis,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_cell_x(o_cell_x), .i_cell_y(o_cell_y), .i_cell_z(o_cell_z),
        .i_t_enter(o_t_enter), .i_cross_axis(o_cross_axis), .i_step_sign(o_step_sign),
        .i_last(o_last), .i_empty_res(o_empty_res), .i_truncated(o_truncated),
        .o_fail_count(fail_count), .o_pending(pending), .o_cell_count(cell_count),
        .o_capped_rays(capped_rays), .o_empty_rays(empty_rays)
    );

    // Receiver: a hold-off counts down first, otherwise stall at random.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            i_out_stall <= 1'b1;
            hold_off <= hold_off - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Hard ceiling on the run, well above the slowest legal run.
    initial begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Offer one ray and hold it until the block accepts it; valid stays high
    // afterwards so back-to-back rays never lower and raise it in one step.
    task automatic send_ray(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] oz, input logic [15:0] dx,
                            input logic [15:0] dy, input logic [15:0] dz,
                            input logic [31:0] ts, input logic [31:0] te,
                            input logic [2:0] ea);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid   <= 1'b1;
        i_origin_x   <= ox;
        i_origin_y   <= oy;
        i_origin_z   <= oz;
        i_dir_x      <= dx;
        i_dir_y      <= dy;
        i_dir_z      <= dz;
        i_t_start    <= ts;
        i_t_end      <= te;
        i_entry_axis <= ea;
        do @(posedge i_clk); while (o_in_stall);
        rays_sent++;
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'(signed'($urandom_range(200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_origin();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'(signed'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
    endfunction

    task automatic send_random_ray();
        logic [31:0] ts, te;
        logic [32:0] sum;
        ts = ($urandom_range(7) == 0) ? $urandom : $urandom_range(32'h0010_0000);
        case ($urandom_range(9))
            0: te = (ts == 0) ? 32'd0 : ts - 32'd1 - $urandom_range(ts - 1);
            1: te = ALL_ONES;
            2: te = $urandom;
            default: begin
                sum = {1'b0, ts} + $urandom_range(32'h0004_0000);
                te  = sum[32] ? ALL_ONES : sum[31:0];
            end
        endcase
        send_ray(rand_origin(), rand_origin(), rand_origin(),
                 rand_dir(), rand_dir(), rand_dir(), ts, te, 3'($urandom));
    endtask

    // Drop valid, wait until every visit has drained, then write the register.
    task automatic write_shift(input logic [3:0] v);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        logic [3:0] shifts[6];
        shifts = '{4'd8, 4'd15, 4'd3, 4'($urandom), 4'd0, 4'd5};

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_shift(4'd0);
        // Directed: extremes, every entry axis code, zero direction, empty, cap.
        send_ray(0, 0, 0, 0, 0, 0, 0, ALL_ONES, 3'd7);
        send_ray(0, 0, 0, 16'h7FFF, 0, 0, 0, ALL_ONES, 3'd0);
        send_ray(0, 0, 0, 16'h8000, 16'h8000, 16'h8000, 0, 32'h0004_0000, 3'd1);
        send_ray(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 16'h7FFF, 16'h8001, 16'h4000, 32'h0001_0000, 32'h0008_0000, 3'd2);
        send_ray(32'h8000_0000, 32'h7FFF_FFFF, 0, 16'h8000, 16'h7FFF, 16'h0001,
                 ALL_ONES, ALL_ONES, 3'd3);
        send_ray(0, 0, 0, 16'h1000, 16'h1000, 16'h1000, 32'h0001_0000, 32'h0000_FFFF, 3'd6);
        send_ray(0, 0, 0, 16'h1000, 0, 0, ALL_ONES, 0, 3'd5);
        send_ray(32'h0000_8000, 32'h0000_8000, 32'h0000_8000,
                 16'h4000, 16'h4000, 16'h4000, 0, 32'h0010_0000, 3'd4);
        send_ray(32'hFFFF_0000, 0, 32'h0001_0000, 16'hC000, 16'h2000, 16'hE000,
                 32'h0000_4000, 32'h0006_0000, 3'd0);
        send_ray(0, 0, 0, 16'h0001, 0, 0, 0, ALL_ONES, 3'd1);
        send_ray(32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F, 16'h5555, 16'hAAAA, 16'h0F0F,
                 32'hFFFF_0000, 32'hFFFF_FFFE, 3'd2);
        write_shift(4'd8);
        send_ray(0, 0, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 0, ALL_ONES, 3'd7);
        send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h0000_0001, 32'h0100_0000, 3'd0);
        write_shift(4'd15);
        send_ray(0, 0, 0, 16'h8000, 16'h7FFF, 0, 0, ALL_ONES, 3'd1);

        // Random blocks: receiver-heavy idling, sender-heavy, then none.
        for (int blk = 0; blk < 6; blk++) begin
            write_shift(shifts[blk]);
            case (blk / 2)
                0: begin send_idle_pct = 15; recv_idle_pct = 88; end
                1: begin send_idle_pct = 88; recv_idle_pct = 15; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            // Long output hold-off while rays keep coming fills the block.
            if (blk == 4) hold_off = 600;
            for (int k = 0; k < 76; k++) send_random_ray();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("covered %0d rays and %0d cell visits over several cell sizes",
                 rays_sent, cell_count);
        $display("rays hitting the step cap: %0d, empty intervals: %0d",
                 capped_rays, empty_rays);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
